[rtl/core/vhvv_pkg.sv]
// Package for the visual hull view vote block: codes, constants and the
// status structs passed between the margin unit, rank unit and top level.
// No dependencies.
`default_nettype none

package vhvv_pkg;

    localparam int MAX_VIEWS_DEF = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_MIN_VIS    = 3'd0;
    localparam logic [2:0] CFG_CARVE_EN   = 3'd1;
    localparam logic [2:0] CFG_TOL_RATIO  = 3'd2;
    localparam logic [2:0] CFG_MIN_VIOL   = 3'd3;
    localparam logic [2:0] CFG_ALLOW_MISS = 3'd4;

    // result verdict codes
    localparam logic [1:0] VERDICT_MARGIN = 2'd0;
    localparam logic [1:0] VERDICT_FEW    = 2'd1;
    localparam logic [1:0] VERDICT_CARVED = 2'd2;

    localparam logic [31:0] FIELD_OUTSIDE = 32'h0001_0000;
    localparam logic [31:0] INT_MAX_Q     = 32'h7FFF_FFFF;
    localparam logic [31:0] INT_MIN_Q     = 32'h8000_0000;
    localparam logic [4:0]  VIOL_MAX      = 5'd31;

    typedef struct packed {
        logic        done;
        logic        viol;
        logic [31:0] margin;
    } vhvv_mrg_res_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
    } vhvv_rank_res_t;

endpackage

`default_nettype wire

[rtl/core/vhvv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vhvv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[rtl/core/vhvv_margin.sv]
// Bit-serial margin unit: shift-add multipliers for distance*depth and
// measured*ratio, violation test, then restoring divider by 2*focal.
// Depends on vhvv_pkg.
`default_nettype none

module vhvv_margin (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        chk,
    input  wire logic [15:0] sd,
    input  wire logic [31:0] depth,
    input  wire logic [23:0] focal,
    input  wire logic [31:0] meas,
    input  wire logic [15:0] ratio,
    output vhvv_pkg::vhvv_mrg_res_t res
);

    localparam int          DVD_W     = 53;
    localparam logic [3:0]  MUL_LAST  = 4'd15;
    localparam logic [5:0]  DIV_LAST  = 6'(DVD_W - 1);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_MUL  = 5'b00010,
        M_PREP = 5'b00100,
        M_DIV  = 5'b01000,
        M_FIN  = 5'b10000
    } m_state_t;

    m_state_t state_reg, state_next;

    logic [15:0]      mag_reg, rat_reg;
    logic [31:0]      depth_reg, meas_reg;
    logic [23:0]      focal_reg;
    logic             neg_reg, chk_reg, viol_reg;
    logic [47:0]      p1_reg, p2_reg;
    logic [5:0]       cnt_reg;
    logic [DVD_W-1:0] dvd_reg;
    logic [24:0]      rem_reg;
    logic [31:0]      q_reg;
    logic             ovf_reg;

    logic [31:0] tol;
    logic [25:0] shifted, divisor;
    logic        ge;
    logic        sat;

    always_comb
    begin
        tol     = (p2_reg[47:16] == 32'd0) ? 32'd1 : p2_reg[47:16];
        shifted = {rem_reg, dvd_reg[DVD_W-1]};
        divisor = {1'b0, focal_reg, 1'b0};
        ge      = (shifted >= divisor);
        sat     = ovf_reg | q_reg[31];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE: if (start) state_next = M_MUL;
            M_MUL:  if (cnt_reg[3:0] == MUL_LAST) state_next = M_PREP;
            M_PREP: state_next = M_DIV;
            M_DIV:  if (cnt_reg == DIV_LAST) state_next = M_FIN;
            M_FIN:  state_next = M_IDLE;
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                M_IDLE:  cnt_reg <= '0;
                M_MUL:   cnt_reg <= (cnt_reg[3:0] == MUL_LAST) ? 6'd0 : cnt_reg + 6'd1;
                M_DIV:   cnt_reg <= cnt_reg + 6'd1;
                default: cnt_reg <= '0;
            endcase
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    neg_reg   <= sd[15];
                    mag_reg   <= sd[15] ? (16'd0 - sd) : sd;
                    rat_reg   <= ratio;
                    depth_reg <= depth;
                    meas_reg  <= meas;
                    focal_reg <= focal;
                    chk_reg   <= chk;
                    p1_reg    <= '0;
                    p2_reg    <= '0;
                end
            end
            M_MUL:
            begin
                // MSB first shift-add
                p1_reg  <= {p1_reg[46:0], 1'b0} + (mag_reg[15] ? {16'd0, depth_reg} : 48'd0);
                p2_reg  <= {p2_reg[46:0], 1'b0} + (rat_reg[15] ? {16'd0, meas_reg} : 48'd0);
                mag_reg <= {mag_reg[14:0], 1'b0};
                rat_reg <= {rat_reg[14:0], 1'b0};
            end
            M_PREP:
            begin
                viol_reg <= chk_reg &&
                            (({1'b0, depth_reg} + {1'b0, tol}) < {1'b0, meas_reg});
                // dividend 2*(n) + focal, n = product << 4
                dvd_reg  <= {1'b0, p1_reg[46:0], 5'd0} + {29'd0, focal_reg};
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
            end
            M_DIV:
            begin
                rem_reg <= ge ? 25'(shifted - divisor) : shifted[24:0];
                q_reg   <= {q_reg[30:0], ge};
                ovf_reg <= ovf_reg | q_reg[31];
                dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.done = (state_reg == M_FIN);
        res.viol = viol_reg;
        if (neg_reg)
        begin
            res.margin = sat ? vhvv_pkg::INT_MIN_Q : (32'd0 - q_reg);
        end
        else
        begin
            res.margin = sat ? vhvv_pkg::INT_MAX_Q : q_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/core/vhvv_rank.sv]
// Rank selector: finds the k-th smallest stored margin by counting, for each
// candidate, the entries below and at or below it, one RAM read per cycle.
// Depends on vhvv_pkg.
`default_nettype none

module vhvv_rank #(
    parameter int MAX_VIEWS = vhvv_pkg::MAX_VIEWS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         start,
    input  wire logic [$clog2(MAX_VIEWS + 1)-1:0]             count,
    input  wire logic [$clog2(MAX_VIEWS + 1)-1:0]             k,
    output logic      [((MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1)-1:0] rd_addr,
    input  wire logic [31:0]                                  rd_data,
    output vhvv_pkg::vhvv_rank_res_t                          res
);

    localparam int CW = $clog2(MAX_VIEWS + 1);
    localparam int AW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;

    typedef enum logic [4:0] {
        R_IDLE = 5'b00001,
        R_CAND = 5'b00010,
        R_LOAD = 5'b00100,
        R_SCAN = 5'b01000,
        R_DONE = 5'b10000
    } r_state_t;

    r_state_t state_reg;

    logic [CW-1:0] count_reg, k_reg, ja_reg, lt_reg, le_reg;
    logic [AW-1:0] i_reg;
    logic [31:0]   cand_reg;

    logic [CW-1:0] lt_new, le_new;
    logic          scan_last, found;

    always_comb
    begin
        lt_new    = lt_reg + CW'($signed(rd_data) <  $signed(cand_reg));
        le_new    = le_reg + CW'($signed(rd_data) <= $signed(cand_reg));
        scan_last = (ja_reg == count_reg);
        found     = (lt_new <= k_reg) && (k_reg < le_new);
    end

    always_comb
    begin
        case (state_reg)
            R_CAND:  rd_addr = i_reg;
            R_LOAD:  rd_addr = '0;
            R_SCAN:  rd_addr = ja_reg[AW-1:0];
            default: rd_addr = i_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            i_reg     <= '0;
            ja_reg    <= '0;
            lt_reg    <= '0;
            le_reg    <= '0;
            count_reg <= '0;
            k_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        count_reg <= count;
                        k_reg     <= k;
                        i_reg     <= '0;
                        state_reg <= R_CAND;
                    end
                end
                R_CAND: state_reg <= R_LOAD;
                R_LOAD:
                begin
                    ja_reg    <= CW'(1);
                    lt_reg    <= '0;
                    le_reg    <= '0;
                    state_reg <= R_SCAN;
                end
                R_SCAN:
                begin
                    if (scan_last)
                    begin
                        if (found)
                        begin
                            state_reg <= R_DONE;
                        end
                        else
                        begin
                            i_reg     <= i_reg + AW'(1);
                            state_reg <= R_CAND;
                        end
                    end
                    else
                    begin
                        ja_reg <= ja_reg + CW'(1);
                        lt_reg <= lt_new;
                        le_reg <= le_new;
                    end
                end
                R_DONE: state_reg <= R_IDLE;
                default: state_reg <= R_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == R_LOAD)
        begin
            cand_reg <= rd_data;
        end
    end

    always_comb
    begin
        res.done  = (state_reg == R_DONE);
        res.value = cand_reg;
    end

endmodule

`default_nettype wire

[rtl/core/visual_hull_view_vote.sv]
// Top level of the visual hull view vote block: config registers, point
// control, margin store; uses vhvv_margin, vhvv_rank, vhvv_ram, vhvv_pkg.
`default_nettype none

// One input beat per camera view of a world point; last_view closes the point
// and yields exactly one result beat. Items are taken one at a time. A valid
// view (view_ok set, focal_len nonzero, store not full) occupies the block
// after its accept for bit-serial shift-add multiply (distance*depth and
// measured*ratio side by side), then the free-space test and dividend setup,
// one-bit-per-cycle restoring division by 2*focal, and the write of the margin
// into the store. An ignored view does not start the margin unit. On the last
// view the block makes its decision; if a margin must be picked, the rank unit
// walks the store through its single RAM read port, candidate by candidate.
// The result is then loaded into the output register, which holds it until
// taken; a following point may start while it waits. field_value is Q16.16,
// +1.0 (65536) whenever verdict is nonzero. Config writes are always
// accepted (cfg_ready is tied high) and must only be made while idle.
module visual_hull_view_vote #(
    parameter int MAX_VIEWS = vhvv_pkg::MAX_VIEWS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        view_ok,
    input  wire logic signed [15:0] signed_distance,
    input  wire logic [31:0] pt_depth,
    input  wire logic [23:0] focal_len,
    input  wire logic        depth_ok,
    input  wire logic [31:0] map_depth,
    input  wire logic        last_view,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic signed [31:0] field_value,
    output logic [1:0]       verdict
);

    localparam int CW   = $clog2(MAX_VIEWS + 1);
    localparam int AW   = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MARGIN = 5'b00010,
        S_DECIDE = 5'b00100,
        S_RANK   = 5'b01000,
        S_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;

    // configuration
    logic [4:0]  min_vis_reg;
    logic        carve_en_reg;
    logic [15:0] tol_ratio_reg;
    logic [4:0]  min_viol_reg;
    logic [3:0]  allow_miss_reg;

    // per-point state
    logic [CW-1:0] count_reg;
    logic [4:0]    viol_reg;
    logic          last_reg;

    // pending result and output register
    logic [31:0] res_field_reg;
    logic [1:0]  res_verdict_reg;
    logic        out_valid_reg;
    logic [31:0] out_field_reg;
    logic [1:0]  out_verdict_reg;

    vhvv_pkg::vhvv_mrg_res_t  mrg;
    vhvv_pkg::vhvv_rank_res_t rnk;

    logic          in_accept, view_used, mrg_start, rank_start;
    logic          too_few, carved, emit_go;
    logic [CW-1:0] k_sel;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [31:0]   neg_pick;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;

    assign view_used = view_ok && (focal_len != 24'd0) && (count_reg < CW'(MAX_VIEWS));
    assign mrg_start = in_accept && view_used;

    always_comb
    begin
        too_few    = (count_reg == '0) || (CMPW'(count_reg) < CMPW'(min_vis_reg));
        carved     = carve_en_reg && (viol_reg >= min_viol_reg);
        cnt_m1     = count_reg - CW'(1);
        // k = min(allowed misses, count - 1)
        if (CMPW'(allow_miss_reg) > CMPW'(cnt_m1))
        begin
            k_sel = cnt_m1;
        end
        else
        begin
            k_sel = CW'(allow_miss_reg);
        end
        rank_start = (state_reg == S_DECIDE) && !too_few && !carved;
        emit_go    = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);
        // negation saturates at the most negative code
        neg_pick   = (rnk.value == vhvv_pkg::INT_MIN_Q) ? vhvv_pkg::INT_MAX_Q
                                                         : (32'd0 - rnk.value);
    end

    vhvv_margin u_margin (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mrg_start),
        .chk   (carve_en_reg && depth_ok && (map_depth != 32'd0)),
        .sd    (signed_distance),
        .depth (pt_depth),
        .focal (focal_len),
        .meas  (map_depth),
        .ratio (tol_ratio_reg),
        .res   (mrg)
    );

    vhvv_ram #(
        .WIDTH (32),
        .DEPTH (MAX_VIEWS)
    ) u_store (
        .clk     (clk),
        .wr_en   (mrg.done),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (mrg.margin),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    vhvv_rank #(
        .MAX_VIEWS (MAX_VIEWS)
    ) u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rank_start),
        .count   (count_reg),
        .k       (k_sel),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (rnk)
    );

    // config writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_vis_reg    <= 5'd1;
            carve_en_reg   <= 1'b0;
            tol_ratio_reg  <= 16'd655;
            min_viol_reg   <= 5'd1;
            allow_miss_reg <= 4'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                vhvv_pkg::CFG_MIN_VIS:    min_vis_reg    <= cfg_data[4:0];
                vhvv_pkg::CFG_CARVE_EN:   carve_en_reg   <= cfg_data[0];
                vhvv_pkg::CFG_TOL_RATIO:  tol_ratio_reg  <= cfg_data;
                vhvv_pkg::CFG_MIN_VIOL:   min_viol_reg   <= cfg_data[4:0];
                vhvv_pkg::CFG_ALLOW_MISS: allow_miss_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // point sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            viol_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new result may replace one taken in the same cycle
            if (emit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        last_reg <= last_view;
                        if (view_used)
                        begin
                            state_reg <= S_MARGIN;
                        end
                        else if (last_view)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end
                S_MARGIN:
                begin
                    if (mrg.done)
                    begin
                        count_reg <= count_reg + CW'(1);
                        if (mrg.viol && (viol_reg < vhvv_pkg::VIOL_MAX))
                        begin
                            viol_reg <= viol_reg + 5'd1;
                        end
                        state_reg <= last_reg ? S_DECIDE : S_IDLE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= (too_few || carved) ? S_EMIT : S_RANK;
                end
                S_RANK:
                begin
                    if (rnk.done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        count_reg     <= '0;
                        viol_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE)
        begin
            res_field_reg   <= vhvv_pkg::FIELD_OUTSIDE;
            res_verdict_reg <= too_few ? vhvv_pkg::VERDICT_FEW : vhvv_pkg::VERDICT_CARVED;
        end
        else if ((state_reg == S_RANK) && rnk.done)
        begin
            res_field_reg   <= neg_pick;
            res_verdict_reg <= vhvv_pkg::VERDICT_MARGIN;
        end

        if (emit_go)
        begin
            out_field_reg   <= res_field_reg;
            out_verdict_reg <= res_verdict_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign field_value = out_field_reg;
    assign verdict     = out_verdict_reg;

endmodule

`default_nettype wire

[tb/sv/tb_visual_hull_view_vote.sv]
// Self-checking testbench for visual_hull_view_vote: directed table, then random
// points checked against an in-bench vote predictor with randomized handshakes.
// Depends on vhvv_pkg and the visual_hull_view_vote RTL.
`default_nettype none

module tb_visual_hull_view_vote;

    // Watchdog, in cycles. The slowest legal run is roughly 1000 views, each
    // busy for a full margin pass, plus sender gaps, plus ~300 points with their
    // rank walks and receiver stalls; this is several times that.
    localparam int LIMIT       = 1_000_000;
    // Quiet time after the last result: covers a full view plus the worst rank
    // walk, with margin.
    localparam int SETTLE      = 400;
    localparam int STORE_DEPTH = vhvv_pkg::MAX_VIEWS_DEF;
    localparam int PHASES      = 10;
    localparam int PHASE_VIEWS = 85;
    localparam int PLAN_LEN    = 34;
    localparam int IDLE_PCT    = 37;

    typedef struct packed {
        logic               ok;
        logic signed [15:0] sd;
        logic [31:0]        depth;
        logic [23:0]        focal;
        logic               dok;
        logic [31:0]        meas;
        logic               last;
    } view_t;

    typedef struct packed {
        logic signed [31:0] field;
        logic [1:0]         verdict;
    } vote_t;

    typedef enum bit {ROW_VIEW, ROW_CFG} row_kind_t;

    // One row of the directed table: either a register write or a view beat.
    // A row with typed set carries its result spelled out by hand.
    typedef struct {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [15:0] val;
        view_t       v;
        bit          typed;
        vote_t       want;
    } plan_row_t;

    localparam logic signed [31:0] OUT_Q = vhvv_pkg::FIELD_OUTSIDE;
    localparam vote_t NO_WANT = '{32'sd0, vhvv_pkg::VERDICT_MARGIN};

    // ------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               view_ok;
    logic signed [15:0] signed_distance;
    logic [31:0]        pt_depth;
    logic [23:0]        focal_len;
    logic               depth_ok;
    logic [31:0]        map_depth;
    logic               last_view;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] field_value;
    logic [1:0]         verdict;

    visual_hull_view_vote uut (
        .clk,
        .rst_n,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .in_valid,
        .in_ready,
        .view_ok,
        .signed_distance,
        .pt_depth,
        .focal_len,
        .depth_ok,
        .map_depth,
        .last_view,
        .out_valid,
        .out_ready,
        .field_value,
        .verdict
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the registers and the per-point
    // store, updated at each accepted beat.
    // ------------------------------------------------------------------
    logic [4:0]  min_vis   = 5'd1;
    logic        carve_en  = 1'b0;
    logic [15:0] tol_ratio = 16'd655;
    logic [4:0]  min_viol  = 5'd1;
    logic [3:0]  allow     = 4'd0;
    int          margins [STORE_DEPTH];
    int          seen      = 0;
    logic [4:0]  viol      = '0;

    vote_t       pending [$];    // votes owed by the DUT, oldest first
    int          err_count = 0;
    int          votes_seen = 0;
    int          cycles    = 0;
    bit          calm      = 1'b0;  // no idling on either side while set
    plan_row_t   plan [PLAN_LEN];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Q16.16 margin = distance(Q12.4) * depth(Q16.16) / focal(Q16.8).
    // Done on magnitudes with round-half-away, then saturated to int32.
    function automatic int scaled_margin(logic signed [15:0] sd, logic [31:0] depth,
                                         logic [23:0] focal);
        logic [63:0] mag;
        logic [63:0] num;
        logic [63:0] quo;
        int          sdx;
        sdx = sd;
        mag = (sdx < 0) ? 64'(-sdx) : 64'(sdx);
        num = (mag * 64'(depth)) << 4;
        quo = ((num << 1) + 64'(focal)) / (64'(focal) << 1);
        if (sdx >= 0)
            return (quo > 64'h7FFF_FFFF) ? int'(vhvv_pkg::INT_MAX_Q) : int'(quo[31:0]);
        if (quo >= 64'h8000_0000)
            return int'(vhvv_pkg::INT_MIN_Q);
        return -int'(quo[31:0]);
    endfunction

    // Fold one accepted view into the point; on the last view produce the vote
    // and clear the point.
    task automatic fold_view(input view_t v, output bit has, output vote_t res);
        int          sorted [STORE_DEPTH];
        int          m;
        int          j;
        int          k;
        logic [63:0] tol;
        has = 1'b0;
        res = '{OUT_Q, vhvv_pkg::VERDICT_FEW};
        // a view past a full store is dropped outright, violation included
        if (v.ok && v.focal != 0 && seen < STORE_DEPTH) begin
            margins[seen] = scaled_margin(v.sd, v.depth, v.focal);
            seen++;
            if (carve_en && v.dok && v.meas != 0) begin
                tol = (64'(v.meas) * 64'(tol_ratio)) >> 16;
                if (tol == 0)
                    tol = 1;
                if (64'(v.depth) + tol < 64'(v.meas) && viol < vhvv_pkg::VIOL_MAX)
                    viol++;
            end
        end
        if (!v.last)
            return;
        has = 1'b1;
        if (seen == 0 || seen < min_vis) begin
            res.verdict = vhvv_pkg::VERDICT_FEW;
        end
        else if (carve_en && viol >= min_viol) begin
            res.verdict = vhvv_pkg::VERDICT_CARVED;
        end
        else begin
            for (int i = 0; i < seen; i++) begin
                m = margins[i];
                j = i;
                while (j > 0 && sorted[j-1] > m) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = m;
            end
            k = (allow > seen - 1) ? seen - 1 : allow;
            m = sorted[k];
            // -INT_MIN does not fit, clamp to INT_MAX
            res.field   = (m == int'(vhvv_pkg::INT_MIN_Q)) ? vhvv_pkg::INT_MAX_Q : -m;
            res.verdict = vhvv_pkg::VERDICT_MARGIN;
        end
        seen = 0;
        viol = '0;
    endtask

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic log_error(input string what);
        err_count++;
        if (err_count <= 10)
            $display("ERROR @%0d: %s", cycles, what);
    endtask

    // ------------------------------------------------------------------
    // Drivers. Valid is raised at a clock edge and held with its payload until
    // the beat is taken; in_valid is lowered only when the next call idles or in a
    // drain, cfg_valid once its write is taken: never two updates in one time step.
    // ------------------------------------------------------------------
    task automatic send_view(input view_t v, input bit typed, input vote_t want);
        bit    has;
        vote_t got;
        while (take_break()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        view_ok         <= v.ok;
        signed_distance <= v.sd;
        pt_depth        <= v.depth;
        focal_len       <= v.focal;
        depth_ok        <= v.dok;
        map_depth       <= v.meas;
        last_view       <= v.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        fold_view(v, has, got);
        if (has)
            pending.insert(pending.size(), typed ? want : got);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            vhvv_pkg::CFG_MIN_VIS:    min_vis   = data[4:0];
            vhvv_pkg::CFG_CARVE_EN:   carve_en  = data[0];
            vhvv_pkg::CFG_TOL_RATIO:  tol_ratio = data;
            vhvv_pkg::CFG_MIN_VIOL:   min_viol  = data[4:0];
            vhvv_pkg::CFG_ALLOW_MISS: allow     = data[3:0];
            default:                  ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Let every owed vote come out, then give the block its full latency so
    // that a trailing ignored beat or a rank walk cannot overlap a reg write.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // lo/hi extremes now and then, a typical value otherwise
    function automatic logic [15:0] pick_value(int lo, int hi, int typical);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'(lo);
        if (r < 16)
            return 16'(hi);
        return 16'(typical);
    endfunction

    task automatic shuffle_regs();
        write_reg(vhvv_pkg::CFG_MIN_VIS, pick_value(0, 16, $urandom_range(1, 4)));
        write_reg(vhvv_pkg::CFG_CARVE_EN, 16'($urandom_range(0, 1)));
        write_reg(vhvv_pkg::CFG_TOL_RATIO, pick_value(0, 65535, $urandom_range(0, 1) ?
                  $urandom_range(0, 65535) : $urandom_range(0, 2000)));
        write_reg(vhvv_pkg::CFG_MIN_VIOL, pick_value(0, 16, $urandom_range(1, 3)));
        write_reg(vhvv_pkg::CFG_ALLOW_MISS, pick_value(0, 15, $urandom_range(0, 4)));
    endtask

    // Random view: mix of full-range and moderate values so margins land both
    // in range and in saturation; measured depth often sits just past the
    // camera depth so the free-space test sees both outcomes.
    function automatic view_t random_view(bit last);
        view_t       v;
        logic [63:0] m;
        v.ok   = 1'b1;
        v.last = last;
        case ($urandom_range(0, 3))
            0:       v.sd = 16'($urandom);
            1:       v.sd = 16'(int'($urandom_range(0, 4000)) - 2000);
            2:       v.sd = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: v.sd = 16'(int'($urandom_range(0, 255)) - 128);
        endcase
        v.depth = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0040_0000);
        v.focal = $urandom_range(0, 1) ? 24'($urandom) : 24'($urandom_range(1, 32'hFFFF));
        if ($urandom_range(0, 99) < 10) begin
            if ($urandom_range(0, 1))
                v.ok = 1'b0;
            else
                v.focal = '0;
        end
        v.dok = ($urandom_range(0, 99) < 85);
        case ($urandom_range(0, 3))
            0: v.meas = $urandom;
            1: begin
                m = 64'(v.depth) + 64'($urandom_range(0, 1 << $urandom_range(0, 20)));
                v.meas = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
            end
            2: v.meas = v.depth;
            default: v.meas = '0;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure, and in-order compare of every
    // taken beat against the oldest owed vote.
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending.size() == 0) begin
                log_error($sformatf("unexpected vote: field %0d verdict %0d",
                                    field_value, verdict));
            end
            else begin
                if (field_value !== pending[0].field || verdict !== pending[0].verdict)
                    log_error($sformatf(
                        "vote %0d: field exp %0d got %0d, verdict exp %0d got %0d",
                        votes_seen, pending[0].field, field_value,
                        pending[0].verdict, verdict));
                void'(pending.pop_front());
            end
            votes_seen++;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        view_t v;
        int    len;
        int    r;
        int    useful;

        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        view_ok         <= 1'b0;
        signed_distance <= '0;
        pt_depth        <= '0;
        focal_len       <= '0;
        depth_ok        <= 1'b0;
        map_depth       <= '0;
        last_view       <= 1'b0;

        // Directed table. Hand-typed votes: empty point, zero focal, half-lsb
        // rounding both signs, both saturation ends (incl. the negation clamp),
        // zero distance, carving at the tolerance edge, and the decision order.
        plan = '{
            // no valid view at all -> outside
            '{ROW_VIEW, '0, '0, '{1'b0, 16'sd0, 32'd0, 24'd0, 1'b0, 32'd0, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_FEW}},
            // zero focal marks the view invalid
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd5, 32'd1, 24'd0, 1'b0, 32'd0, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_FEW}},
            // 16/32 = 0.5 rounds away from zero
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd1, 32'd1, 24'd32, 1'b0, 32'd0, 1'b1},
              1'b1, '{-32'sd1, vhvv_pkg::VERDICT_MARGIN}},
            '{ROW_VIEW, '0, '0, '{1'b1, -16'sd1, 32'd1, 24'd32, 1'b0, 32'd0, 1'b1},
              1'b1, '{32'sd1, vhvv_pkg::VERDICT_MARGIN}},
            // margin clamps to INT_MIN, negation clamps to INT_MAX
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sh8000, 32'hFFFF_FFFF, 24'd1, 1'b0, 32'd0, 1'b1},
              1'b1, '{vhvv_pkg::INT_MAX_Q, vhvv_pkg::VERDICT_MARGIN}},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sh7FFF, 32'hFFFF_FFFF, 24'd1, 1'b0, 32'd0, 1'b1},
              1'b1, '{32'sh8000_0001, vhvv_pkg::VERDICT_MARGIN}},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd0, 32'd0, 24'hFF_FFFF, 1'b1, 32'hFFFF_FFFF,
              1'b1}, 1'b1, '{32'sd0, vhvv_pkg::VERDICT_MARGIN}},
            // multi-view point with a noise beat in the middle
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd100, 32'h0002_0000, 24'h180, 1'b0, 32'd0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, -16'sd5000, 32'h8000, 24'h7FF, 1'b1, 32'd7, 1'b0},
              1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b0, 16'sh7FFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1,
              32'hFFFF_FFFF, 1'b0}, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd2000, 32'h0005_0000, 24'hFF_FFFF, 1'b0, 32'd0,
              1'b1}, 1'b0, NO_WANT},
            // rank past the view count clamps to the largest margin
            '{ROW_CFG, vhvv_pkg::CFG_ALLOW_MISS, 16'd15, '0, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, -16'sd300, 32'h0003_0000, 24'h100, 1'b0, 32'd0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd7, 32'h0012_D687, 24'd3, 1'b0, 32'd0, 1'b0},
              1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd32000, 32'd16, 24'h80_0000, 1'b0, 32'd0, 1'b1},
              1'b0, NO_WANT},
            // carving with zero ratio: tolerance floors at one lsb
            '{ROW_CFG, vhvv_pkg::CFG_CARVE_EN, 16'd1, '0, 1'b0, NO_WANT},
            '{ROW_CFG, vhvv_pkg::CFG_TOL_RATIO, 16'd0, '0, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h0001_0000, 24'h100, 1'b1, 32'h0001_0002,
              1'b1}, 1'b1, '{OUT_Q, vhvv_pkg::VERDICT_CARVED}},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h0001_0000, 24'h100, 1'b1, 32'h0001_0001,
              1'b1}, 1'b1, '{32'shFFFF_0000, vhvv_pkg::VERDICT_MARGIN}},
            // no depth pixel: the free-space test is skipped
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h0001_0000, 24'h100, 1'b0, 32'hFFFF_FFFF,
              1'b1}, 1'b1, '{32'shFFFF_0000, vhvv_pkg::VERDICT_MARGIN}},
            // too-few-views wins over carving
            '{ROW_CFG, vhvv_pkg::CFG_TOL_RATIO, 16'd65535, '0, 1'b0, NO_WANT},
            '{ROW_CFG, vhvv_pkg::CFG_MIN_VIOL, 16'd2, '0, 1'b0, NO_WANT},
            '{ROW_CFG, vhvv_pkg::CFG_MIN_VIS, 16'd3, '0, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h100, 24'h100, 1'b1, 32'hFFFF_FFFF, 1'b0},
              1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h100, 24'h100, 1'b1, 32'hFFFF_FFFF, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_FEW}},
            '{ROW_CFG, vhvv_pkg::CFG_MIN_VIS, 16'd2, '0, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h100, 24'h100, 1'b1, 32'hFFFF_FFFF, 1'b0},
              1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h100, 24'h100, 1'b1, 32'hFFFF_FFFF, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_CARVED}},
            // zero violation threshold carves any counted point
            '{ROW_CFG, vhvv_pkg::CFG_MIN_VIOL, 16'd0, '0, 1'b0, NO_WANT},
            '{ROW_CFG, vhvv_pkg::CFG_MIN_VIS, 16'd16, '0, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h0001_0000, 24'h100, 1'b0, 32'd0, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_FEW}},
            '{ROW_CFG, vhvv_pkg::CFG_MIN_VIS, 16'd0, '0, 1'b0, NO_WANT},
            '{ROW_VIEW, '0, '0, '{1'b1, 16'sd16, 32'h0001_0000, 24'h100, 1'b0, 32'd0, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_CARVED}},
            // empty point is outside even with no minimum
            '{ROW_VIEW, '0, '0, '{1'b0, 16'sd0, 32'd0, 24'd1, 1'b0, 32'd0, 1'b1},
              1'b1, '{OUT_Q, vhvv_pkg::VERDICT_FEW}}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                drain();
                write_reg(plan[i].idx, plan[i].val);
            end
            else begin
                send_view(plan[i].v, plan[i].typed, plan[i].want);
            end
        end

        // Random phases: fresh register set each phase, then whole points of
        // random views. Most points are short; some fill the store, some
        // overflow it. One phase in the middle runs with no idling at all.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            calm = (p == PHASES / 2);
            shuffle_regs();
            useful = 0;
            while (useful < PHASE_VIEWS) begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    len = $urandom_range(1, 5);
                else if (r < 92)
                    len = $urandom_range(6, 16);
                else
                    len = $urandom_range(17, 20);
                for (int n = 0; n < len; n++) begin
                    v = random_view(n == len - 1);
                    if (v.ok && v.focal != 0)
                        useful++;
                    send_view(v, 1'b0, NO_WANT);
                end
            end
        end
        calm = 1'b0;

        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/vhvv_pkg.sv
rtl/core/vhvv_ram.sv
rtl/core/vhvv_margin.sv
rtl/core/vhvv_rank.sv
rtl/core/visual_hull_view_vote.sv
tb/sv/tb_visual_hull_view_vote.sv
